// ===== src/arst_pkg.sv =====
// ----------------------------------------------------------------------------
// arst_pkg
// Shared types and constants for the address range symbol table: request and
// response beats, stored region entries, status codes and the
// controller/datapath interface.
// ----------------------------------------------------------------------------
package arst_pkg;

  // default table depth
  localparam int unsigned MAX_ENTRIES_DEF = 64;

  // field widths
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned IDX_W  = 6;

  // request kinds
  typedef enum logic {
    REQ_ADD    = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_type_e;

  // response status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // request beat
  typedef struct packed {
    req_type_e          req_type;
    logic [ADDR_W-1:0]  address;
    logic [ADDR_W-1:0]  region_length;
    logic [TAG_W-1:0]   tag_in;
  } req_t;

  // response beat
  typedef struct packed {
    status_e            status;
    logic [IDX_W-1:0]   entry_index;
    logic [TAG_W-1:0]   tag_out;
  } rsp_t;

  // one stored region
  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [ADDR_W-1:0]  length;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;     // latch the incoming request
    logic add;         // append the latched region
    logic scan_start;  // clear the lookup result and slot counter
    logic rd_issue;    // read the slot under the counter
    logic load_out;    // move the result into the output register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_is_lookup;  // incoming beat is a lookup
    logic empty;         // no slot used yet
    logic scan_last;     // counter is on the last used slot
    logic out_free;      // output register can take a result
  } sts_t;

endpackage

// ===== src/arst_ram.sv =====
// ----------------------------------------------------------------------------
// arst_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module arst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/arst_ctrl.sv =====
// ----------------------------------------------------------------------------
// arst_ctrl
// Sequencer for the region table: takes one request at a time, runs an
// append or a slot-by-slot scan, then hands the result to the output stage.
// ----------------------------------------------------------------------------
module arst_ctrl
  import arst_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ADD  = 5'b00010,
    S_SCAN = 5'b00100,
    S_LAST = 5'b01000,
    S_RESP = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          if (sts_i.in_is_lookup) begin
            cmd_o.scan_start = 1'b1;
            state_d = sts_i.empty ? S_RESP : S_SCAN;
          end else begin
            state_d = S_ADD;
          end
        end
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = S_RESP;
      end
      S_SCAN: begin
        cmd_o.rd_issue = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_LAST;
        end
      end
      // last read data is compared here
      S_LAST: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/arst_dp.sv =====
// ----------------------------------------------------------------------------
// arst_dp
// Datapath for the region table: request register, fill count, slot
// counter, region memory, range compare, result and output registers.
// ----------------------------------------------------------------------------
module arst_dp
  import arst_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o,
  input  cmd_t cmd_i,
  output sts_t sts_o
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned FW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned EW = $bits(entry_t);

  req_t            req_q;
  logic [FW-1:0]   fill_q;
  logic [AW-1:0]   cnt_q;
  logic            rd_pend_q;
  logic [AW-1:0]   rd_addr_q;
  status_e         res_status_q;
  logic [AW-1:0]   res_idx_q;
  logic [TAG_W-1:0] res_tag_q;
  logic            out_valid_q;
  rsp_t            out_rsp_q;

  logic            full;
  logic            wr_en;
  entry_t          wr_entry;
  entry_t          rd_entry;
  logic [ADDR_W-1:0] reg_end;
  logic            hit;

  assign full = (fill_q == FW'(MAX_ENTRIES));

  // status toward the controller
  assign sts_o.in_is_lookup = (in_req_i.req_type == REQ_LOOKUP);
  assign sts_o.empty        = (fill_q == '0);
  assign sts_o.scan_last    = (FW'(cnt_q) == (fill_q - FW'(1)));
  assign sts_o.out_free     = !out_valid_q || !out_stall_i;

  // request register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_req_i;
    end
  end

  // region memory
  assign wr_en           = cmd_i.add && !full;
  assign wr_entry.base   = req_q.address;
  assign wr_entry.length = req_q.region_length;
  assign wr_entry.tag    = req_q.tag_in;

  arst_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (cnt_q),
    .rdata_o (rd_entry)
  );

  // fill count, slot counter and read tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      if (wr_en) begin
        fill_q <= fill_q + FW'(1);
      end
      if (cmd_i.scan_start) begin
        cnt_q <= '0;
      end else if (cmd_i.rd_issue) begin
        cnt_q <= cnt_q + AW'(1);
      end
      rd_pend_q <= cmd_i.rd_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      rd_addr_q <= cnt_q;
    end
  end

  // range compare, end address wraps at 32 bits
  assign reg_end = rd_entry.base + rd_entry.length;
  assign hit = rd_pend_q && (rd_entry.length != '0) &&
               (req_q.address >= rd_entry.base) && (req_q.address < reg_end);

  // result register, a later hit overrides an earlier one
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      res_status_q <= ST_NOT_FOUND;
      res_idx_q    <= '0;
      res_tag_q    <= '0;
    end else if (cmd_i.add) begin
      res_status_q <= full ? ST_FULL : ST_OK;
      res_idx_q    <= full ? '0 : fill_q[AW-1:0];
      res_tag_q    <= '0;
    end else if (hit) begin
      res_status_q <= ST_OK;
      res_idx_q    <= rd_addr_q;
      res_tag_q    <= rd_entry.tag;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_rsp_q.status      <= res_status_q;
      out_rsp_q.entry_index <= IDX_W'(res_idx_q);
      out_rsp_q.tag_out     <= res_tag_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ===== src/address_range_symbol_table_core.sv =====
// ----------------------------------------------------------------------------
// address_range_symbol_table_core
// Table of address regions with append and last-match range lookup.
// ----------------------------------------------------------------------------
// One request is handled at a time and each gives exactly one response beat.
// An add runs through the add and response states; a lookup on an empty
// table goes straight to the response state, otherwise the scan reads one
// used slot per cycle through the single read port of the region memory and
// compares it against the probe address. The next request beat can be taken
// after the response is loaded into the output register; a stalled output
// register holds the sequencer and with it the input. The region memory needs
// no clearing pass after reset: only slots below the fill count are read. Adds
// to a full table are refused with the table-full status. Response beats wait
// in an output register while the far side stalls.
module address_range_symbol_table_core
  import arst_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  arst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table storage and compare
  arst_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the address range symbol table: a directed pass over
// empty-table, zero-length, overlap and wrap-around regions, then random adds
// and lookups aimed at stored regions, filling the table and pushing adds past
// full, under random sender gaps and receiver stalls. A scoreboard mirrors the
// region table and checks every response beat field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import arst_pkg::*;

  localparam int unsigned SLOTS      = MAX_ENTRIES_DEF;
  localparam int unsigned RAND_ITEMS = 700;

  // scoreboard with a shadow copy of the region table
  class region_table_scoreboard;
    logic [ADDR_W-1:0] base_mem [SLOTS];
    logic [ADDR_W-1:0] len_mem  [SLOTS];
    logic [TAG_W-1:0]  tag_mem  [SLOTS];
    int unsigned       used_slots;
    rsp_t              pending_rsp [$];
    int                err_count;

    function new();
      foreach (base_mem[s]) begin
        base_mem[s] = '0;
        len_mem[s]  = '0;
        tag_mem[s]  = '0;
      end
      used_slots = 0;
      err_count  = 0;
    endfunction

    // one line per mismatch, log kept short on a flood
    task report(input string msg);
      if (err_count < 40) $display("mismatch at %0t: %s", $realtime, msg);
      err_count++;
    endtask

    // append on add, last-match range scan on lookup
    function rsp_t resolve_request(input req_t r);
      rsp_t              o;
      logic [ADDR_W-1:0] lim;
      o.status      = ST_OK;
      o.entry_index = '0;
      o.tag_out     = '0;
      if (r.req_type == REQ_ADD) begin
        if (used_slots >= SLOTS) begin
          o.status = ST_FULL;
        end else begin
          base_mem[used_slots] = r.address;
          len_mem[used_slots]  = r.region_length;
          tag_mem[used_slots]  = r.tag_in;
          o.entry_index        = IDX_W'(used_slots);
          used_slots++;
        end
      end else begin
        o.status = ST_NOT_FOUND;
        for (int s = 0; s < SLOTS; s++) begin
          lim = base_mem[s] + len_mem[s];
          if (len_mem[s] != '0 && r.address >= base_mem[s] && r.address < lim) begin
            o.status      = ST_OK;
            o.entry_index = IDX_W'(s);
            o.tag_out     = tag_mem[s];
          end
        end
      end
      return o;
    endfunction

    function void note_request(input req_t r);
      pending_rsp.push_back(resolve_request(r));
    endfunction

    task check_response(input rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        report($sformatf("response beat with nothing pending: %h", got));
      end else begin
        want = pending_rsp.pop_front();
        if (got.status !== want.status)
          report($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.entry_index !== want.entry_index)
          report($sformatf("entry_index got %0d want %0d", got.entry_index,
                           want.entry_index));
        if (got.tag_out !== want.tag_out)
          report($sformatf("tag_out got %h want %h", got.tag_out, want.tag_out));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  req_t in_req_i    = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_rsp_o;

  region_table_scoreboard sb = new();
  int   n_accepted = 0;
  req_t added_regions [$];

  address_range_symbol_table_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watch both channels for accepted beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_response(out_rsp_o);
      if (in_valid_i && !in_stall_o) begin
        sb.note_request(in_req_i);
        n_accepted++;
      end
    end
  end

  // receiver stall pattern, with one long hold-off once traffic is going
  initial begin : rx_stall
    int mode;
    int run;
    int k;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      run  = $urandom_range(20, 200);
      for (k = 0; k < run; k++) begin
        @(posedge clk_i);
        if (!held && n_accepted >= 150) begin
          out_stall_i <= 1'b1;
          repeat (400) @(posedge clk_i);
          held = 1'b1;
        end else begin
          case (mode)
            0:       out_stall_i <= 1'b0;
            1:       out_stall_i <= ($urandom_range(0, 99) < 30);
            2:       out_stall_i <= (k % 4 == 0);
            default: out_stall_i <= ($urandom_range(0, 99) < 70);
          endcase
        end
      end
    end
  end

  // build one request; adds are remembered so lookups can aim at them
  function automatic req_t make_req(input req_type_e kind, input logic [31:0] addr,
                                    input logic [31:0] len, input logic [15:0] tag);
    req_t r;
    r.req_type      = kind;
    r.address       = addr;
    r.region_length = len;
    r.tag_in        = tag;
    if (kind == REQ_ADD) added_regions.push_back(r);
    return r;
  endfunction

  // random region: clustered bases for overlaps, lengths from zero to all ones
  function automatic req_t random_add();
    logic [31:0] base;
    logic [31:0] len;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      base = 32'h1000_0000 + $urandom_range(0, 32'hFFFF);
    else if (pick < 55) base = 32'hFFFF_0000 + $urandom_range(0, 32'hFFFF);
    else if (pick < 65) base = $urandom_range(0, 32'hFFF);
    else                base = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 10)      len = '0;
    else if (pick < 25) len = $urandom_range(1, 16);
    else if (pick < 55) len = $urandom_range(1, 32'h1_0000);
    else if (pick < 70) len = $urandom;
    else if (pick < 80) len = 32'hFFFF_FFFF;
    else if (pick < 90) len = $urandom_range(32'h1_0000, 32'h10_0000);
    else                len = $urandom_range(1, 32'h100);
    return make_req(REQ_ADD, base, len, 16'($urandom));
  endfunction

  // probe near the edges of a stored region, or anywhere
  function automatic req_t random_lookup();
    req_t        e;
    logic [31:0] addr;
    int          n;
    n = (added_regions.size() > SLOTS) ? SLOTS : added_regions.size();
    if (n > 0 && $urandom_range(0, 99) < 70) begin
      e = added_regions[$urandom_range(0, n - 1)];
      case ($urandom_range(0, 4))
        0:       addr = e.address;
        1:       addr = e.address - 1;
        2:       addr = e.address + e.region_length - 1;
        3:       addr = e.address + e.region_length;
        default: addr = (e.region_length == '0) ? e.address
                        : e.address + ($urandom % e.region_length);
      endcase
    end else begin
      case ($urandom_range(0, 3))
        0:       addr = '0;
        1:       addr = 32'hFFFF_FFFF;
        2:       addr = 32'h1000_0000 + $urandom_range(0, 32'hFFFF);
        default: addr = $urandom;
      endcase
    end
    return make_req(REQ_LOOKUP, addr, $urandom, 16'($urandom));
  endfunction

  function automatic req_t random_req();
    int add_pct;
    add_pct = (added_regions.size() < SLOTS) ? 20 : 8;
    if ($urandom_range(0, 99) < add_pct) return random_add();
    return random_lookup();
  endfunction

  // hold the beat until it is taken
  task automatic offer(input req_t r);
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // stop sending until every response is back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  // stimulus
  initial begin : stim
    int  sent;
    int  burst;
    bit  drained;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table lookups, with ignored fields at their extremes
    offer(make_req(REQ_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF));
    offer(make_req(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 16'h0000));
    // basic region and its edges
    offer(make_req(REQ_ADD,    32'h0000_1000, 32'h0000_0100, 16'hFFFF));
    offer(make_req(REQ_LOOKUP, 32'h0000_1000, 32'h0, 16'h0));
    offer(make_req(REQ_LOOKUP, 32'h0000_10FF, 32'h0, 16'h0));
    offer(make_req(REQ_LOOKUP, 32'h0000_1100, 32'h0, 16'h0));
    offer(make_req(REQ_LOOKUP, 32'h0000_0FFF, 32'h0, 16'h0));
    // zero length slot is used but never matches
    offer(make_req(REQ_ADD,    32'h0000_1080, 32'h0, 16'h1234));
    offer(make_req(REQ_LOOKUP, 32'h0000_1080, 32'h0, 16'h0));
    // overlap, last match wins
    offer(make_req(REQ_ADD,    32'h0000_1080, 32'h0000_0010, 16'h0000));
    offer(make_req(REQ_LOOKUP, 32'h0000_1085, 32'h0, 16'h0));
    // region whose end wraps past the top
    offer(make_req(REQ_ADD,    32'hFFFF_FFF0, 32'h0000_0020, 16'hA5A5));
    offer(make_req(REQ_LOOKUP, 32'hFFFF_FFF8, 32'h0, 16'h0));
    offer(make_req(REQ_LOOKUP, 32'h0000_0008, 32'h0, 16'h0));
    // near-full address space region
    offer(make_req(REQ_ADD,    32'h0000_0000, 32'hFFFF_FFFF, 16'h5A5A));
    offer(make_req(REQ_LOOKUP, 32'hFFFF_FFFE, 32'h0, 16'h0));
    offer(make_req(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0, 16'h0));
    offer(make_req(REQ_LOOKUP, 32'h0000_1085, 32'h0, 16'h0));
    // top byte whose end wraps to zero
    offer(make_req(REQ_ADD,    32'hFFFF_FFFF, 32'h0000_0001, 16'h0001));
    offer(make_req(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0, 16'h0));
    drain();

    // random bursts with random gaps, one full drain midway
    sent    = 0;
    drained = 1'b0;
    while (sent < RAND_ITEMS) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++) begin
        offer(random_req());
        sent++;
      end
      if (!drained && sent >= RAND_ITEMS / 2) begin
        drain();
        drained = 1'b1;
      end else if ($urandom_range(0, 2) != 0) begin
        pause($urandom_range(1, 8));
      end
    end

    // wait out the last responses and any stray beat
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (3 * SLOTS) @(posedge clk_i);
    if (sb.pending_rsp.size() != 0)
      sb.report($sformatf("%0d responses never arrived", sb.pending_rsp.size()));
    if (sb.err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
src/arst_pkg.sv
src/arst_ram.sv
src/arst_ctrl.sv
src/arst_dp.sv
src/address_range_symbol_table_core.sv
dv/tb_top.sv
